// File: sv/erl_pkg.sv
// Event ring log: shared widths, operation codes and the command/status
// structs that join the controller to the datapath. No dependencies.
package erl_pkg;

    localparam int KIND_W           = 2;
    localparam int ID_W             = 32;
    localparam int PAY_W            = 32;
    localparam int CNT_W            = 6;
    localparam int TOTAL_W          = 32;
    localparam int MAX_RESULTS      = 32;
    localparam int DEF_CAPACITY     = 32;
    localparam int DEF_PAYLOAD_BITS = 32;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic write;      // store the accepted record at the write pointer
        logic capture;    // start a walk: clear scan/emit, latch limit and target
        logic rd;         // read the slot under the scan position
        logic scan_inc;   // advance the scan position
        logic clr_pend;   // mark the slot under the scan position synced
        logic out_rec;    // load the output register with the slot just read
        logic out_empty;  // load the output register with an empty final result
    } erl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic peek_none;  // peek request would return nothing
        logic cur_pend;   // slot under the scan position holds an unsynced record
        logic scan_done;  // every slot has been walked
        logic id_le;      // id read from the slot is at most the mark limit
        logic last_hit;   // the record being loaded is the last of this peek
        logic m_fire;     // output register taken this cycle
    } erl_status_t;

endpackage

// File: sv/event_ring_log_with_sync_marks.sv
// Event ring log with synced marks: top level.
// Depends on erl_pkg, erl_ctrl and erl_datapath.
//
// Usage:
//   Input channel (s_*): one request per handshake. kind selects write
//   record, peek unsynced, or mark synced up to event_id.
//   Result channel (m_*): each request gives one or more results; m_last
//   flags the final one. Status fields show the state after the request.
//   Timing: one request at a time, taken only in the idle state.
//   - write / unused kind: result registered 1 cycle after acceptance.
//   - peek: walks the ring oldest to newest one slot per cycle from the
//     scan counter; each hit adds a state for the registered memory
//     read, then waits for its result to be taken.
//   - mark: walks every slot; a pending slot is read, then its id is
//     compared with event_id; others are passed over.
//   Reset (aresetn low, synchronous) empties the ring and clears counters,
//   pending bits and the overflow flag; no memory clearing pass is needed.
//   A stalled receiver holds the result register and pauses the walk; no
//   request is accepted until the last result has been taken.
module event_ring_log_with_sync_marks #(
    parameter int CAPACITY     = erl_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = erl_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [erl_pkg::KIND_W-1:0]  s_kind,
    input  logic [erl_pkg::ID_W-1:0]    s_event_id,
    input  logic [erl_pkg::PAY_W-1:0]   s_payload,
    input  logic [erl_pkg::CNT_W-1:0]   s_max_wanted,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_out_valid,
    output logic [erl_pkg::ID_W-1:0]    m_out_event_id,
    output logic [erl_pkg::PAY_W-1:0]   m_out_payload,
    output logic                        m_last,
    output logic [erl_pkg::CNT_W-1:0]   m_unsynced_count,
    output logic [erl_pkg::CNT_W-1:0]   m_stored_count,
    output logic [erl_pkg::TOTAL_W-1:0] m_total_written,
    output logic                        m_overflowed
);
    import erl_pkg::*;

    erl_cmd_t    cmd;
    erl_status_t sts;

    erl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    erl_datapath #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_event_id       (s_event_id),
        .s_payload        (s_payload),
        .s_max_wanted     (s_max_wanted),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_valid      (m_out_valid),
        .m_out_event_id   (m_out_event_id),
        .m_out_payload    (m_out_payload),
        .m_last           (m_last),
        .m_unsynced_count (m_unsynced_count),
        .m_stored_count   (m_stored_count),
        .m_total_written  (m_total_written),
        .m_overflowed     (m_overflowed)
    );

endmodule

// File: sv/erl_ctrl.sv
// Event ring log controller: sequences writes, peek walks and mark walks.
// Depends on erl_pkg for the operation codes and command/status structs.
module erl_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [erl_pkg::KIND_W-1:0] s_kind,
    input  erl_pkg::erl_status_t       sts,
    output erl_pkg::erl_cmd_t          cmd
);
    import erl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEEK_SCAN,
        S_PEEK_DATA,
        S_PEEK_OUT,
        S_MARK_RD,
        S_MARK_CMP,
        S_DONE_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_WRITE: begin
                            cmd.write     = 1'b1;
                            cmd.out_empty = 1'b1;
                            state_next    = S_DONE_OUT;
                        end
                        KIND_PEEK: begin
                            cmd.capture = 1'b1;
                            if (sts.peek_none) begin
                                cmd.out_empty = 1'b1;
                                state_next    = S_DONE_OUT;
                            end else begin
                                state_next = S_PEEK_SCAN;
                            end
                        end
                        KIND_MARK: begin
                            cmd.capture = 1'b1;
                            state_next  = S_MARK_RD;
                        end
                        default: begin
                            cmd.out_empty = 1'b1;
                            state_next    = S_DONE_OUT;
                        end
                    endcase
                end
            end
            S_PEEK_SCAN: begin
                if (sts.scan_done) begin
                    cmd.out_empty = 1'b1;
                    state_next    = S_DONE_OUT;
                end else if (sts.cur_pend) begin
                    cmd.rd     = 1'b1;
                    state_next = S_PEEK_DATA;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_PEEK_DATA: begin
                cmd.out_rec  = 1'b1;
                cmd.scan_inc = 1'b1;
                state_next   = sts.last_hit ? S_DONE_OUT : S_PEEK_OUT;
            end
            S_PEEK_OUT: begin
                if (sts.m_fire) begin
                    state_next = S_PEEK_SCAN;
                end
            end
            S_MARK_RD: begin
                if (sts.scan_done) begin
                    cmd.out_empty = 1'b1;
                    state_next    = S_DONE_OUT;
                end else if (sts.cur_pend) begin
                    cmd.rd     = 1'b1;
                    state_next = S_MARK_CMP;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_MARK_CMP: begin
                cmd.clr_pend = sts.id_le;
                cmd.scan_inc = 1'b1;
                state_next   = S_MARK_RD;
            end
            S_DONE_OUT: begin
                if (sts.m_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a request is only taken with no result outstanding
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != S_PEEK_OUT))
        else $error("request accepted into a result wait");

    // a record load is always preceded by a slot read
    a_data_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PEEK_DATA) |-> $past(cmd.rd))
        else $error("peek data without a read");

    a_cmp_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MARK_CMP) |-> $past(cmd.rd))
        else $error("mark compare without a read");

endmodule

// File: sv/erl_datapath.sv
// Event ring log datapath: id/payload memories, pending bits, counters,
// scan position and the output register. Depends on erl_pkg.
module erl_datapath #(
    parameter int CAPACITY     = erl_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = erl_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [erl_pkg::ID_W-1:0]    s_event_id,
    input  logic [erl_pkg::PAY_W-1:0]   s_payload,
    input  logic [erl_pkg::CNT_W-1:0]   s_max_wanted,
    input  erl_pkg::erl_cmd_t           cmd,
    output erl_pkg::erl_status_t        sts,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_out_valid,
    output logic [erl_pkg::ID_W-1:0]    m_out_event_id,
    output logic [erl_pkg::PAY_W-1:0]   m_out_payload,
    output logic                        m_last,
    output logic [erl_pkg::CNT_W-1:0]   m_unsynced_count,
    output logic [erl_pkg::CNT_W-1:0]   m_stored_count,
    output logic [erl_pkg::TOTAL_W-1:0] m_total_written,
    output logic                        m_overflowed
);
    import erl_pkg::*;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int OCC_W   = $clog2(CAPACITY + 1);
    localparam int STORE_W = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam int CMP_W   = (OCC_W > CNT_W) ? OCC_W : CNT_W;

    logic [ID_W-1:0]    ids_mem [CAPACITY];
    logic [STORE_W-1:0] pay_mem [CAPACITY];

    logic [IDX_W-1:0]    wp_reg, wp_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                ovf_reg, ovf_next;
    logic [CAPACITY-1:0] pend_reg, pend_next;
    logic [OCC_W-1:0]    ucnt_reg, ucnt_next;
    logic [OCC_W-1:0]    scan_reg, scan_next;
    logic [CNT_W-1:0]    emit_reg, emit_next;
    logic [CNT_W-1:0]    target_reg, target_next;
    logic [ID_W-1:0]     lim_reg, lim_next;
    logic                mvalid_reg, mvalid_next;

    logic [ID_W-1:0]     id_q_reg;
    logic [STORE_W-1:0]  pay_q_reg;
    logic                out_valid_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [PAY_W-1:0]    out_pay_reg;
    logic                last_reg;

    logic                full;
    logic [IDX_W-1:0]    start;
    logic [IDX_W:0]      slot_sum;
    logic [IDX_W-1:0]    slot;
    logic [CNT_W-1:0]    want_clip;
    logic [CNT_W-1:0]    target_c;
    logic                new_pend;

    assign full = (occ_reg == OCC_W'(CAPACITY));

    // oldest record sits at the write pointer once the ring has wrapped
    assign start    = full ? wp_reg : '0;
    assign slot_sum = {1'b0, start} + {1'b0, scan_reg[IDX_W-1:0]};
    always_comb begin
        if (slot_sum >= (IDX_W + 1)'(CAPACITY)) begin
            slot = IDX_W'(slot_sum - (IDX_W + 1)'(CAPACITY));
        end else begin
            slot = slot_sum[IDX_W-1:0];
        end
    end

    // peek returns min(max_wanted, 32, pending records)
    assign want_clip = (s_max_wanted > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
                                                            : s_max_wanted;
    assign target_c  = (CMP_W'(ucnt_reg) < CMP_W'(want_clip)) ? CNT_W'(ucnt_reg)
                                                              : want_clip;
    assign new_pend  = (s_event_id != '0);

    always_comb begin
        wp_next     = wp_reg;
        occ_next    = occ_reg;
        total_next  = total_reg;
        ovf_next    = ovf_reg;
        pend_next   = pend_reg;
        ucnt_next   = ucnt_reg;
        scan_next   = scan_reg;
        emit_next   = emit_reg;
        target_next = target_reg;
        lim_next    = lim_reg;
        mvalid_next = mvalid_reg;

        if (cmd.write) begin
            pend_next[wp_reg] = new_pend;
            ucnt_next  = ucnt_reg + OCC_W'(new_pend) - OCC_W'(pend_reg[wp_reg]);
            wp_next    = (wp_reg == IDX_W'(CAPACITY - 1)) ? '0 : wp_reg + 1'b1;
            total_next = total_reg + 1'b1;
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                occ_next = occ_reg + 1'b1;
            end
        end
        if (cmd.capture) begin
            scan_next   = '0;
            emit_next   = '0;
            target_next = target_c;
            lim_next    = s_event_id;
        end
        if (cmd.clr_pend) begin
            pend_next[slot] = 1'b0;
            ucnt_next       = ucnt_reg - 1'b1;
        end
        if (cmd.scan_inc) begin
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.out_rec) begin
            emit_next = emit_reg + 1'b1;
        end
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        if (cmd.out_rec || cmd.out_empty) begin
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            occ_reg    <= '0;
            total_reg  <= '0;
            ovf_reg    <= 1'b0;
            pend_reg   <= '0;
            ucnt_reg   <= '0;
            scan_reg   <= '0;
            emit_reg   <= '0;
            target_reg <= '0;
            lim_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            wp_reg     <= wp_next;
            occ_reg    <= occ_next;
            total_reg  <= total_next;
            ovf_reg    <= ovf_next;
            pend_reg   <= pend_next;
            ucnt_reg   <= ucnt_next;
            scan_reg   <= scan_next;
            emit_reg   <= emit_next;
            target_reg <= target_next;
            lim_reg    <= lim_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // record memories, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            ids_mem[wp_reg] <= s_event_id;
        end
        if (cmd.rd) begin
            id_q_reg <= ids_mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            pay_mem[wp_reg] <= s_payload[STORE_W-1:0];
        end
        if (cmd.rd) begin
            pay_q_reg <= pay_mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_rec) begin
            out_valid_reg <= 1'b1;
            out_id_reg    <= id_q_reg;
            out_pay_reg   <= PAY_W'(pay_q_reg);
            last_reg      <= sts.last_hit;
        end else if (cmd.out_empty) begin
            out_valid_reg <= 1'b0;
            out_id_reg    <= '0;
            out_pay_reg   <= '0;
            last_reg      <= 1'b1;
        end
    end

    assign sts.peek_none = (target_c == '0);
    assign sts.cur_pend  = pend_reg[slot];
    assign sts.scan_done = (scan_reg == OCC_W'(CAPACITY));
    assign sts.id_le     = (id_q_reg <= lim_reg);
    assign sts.last_hit  = (CNT_W'(emit_reg + 1'b1) == target_reg);
    assign sts.m_fire    = mvalid_reg && m_ready;

    // status is live state; it holds still while a result is outstanding
    assign m_valid          = mvalid_reg;
    assign m_out_valid      = out_valid_reg;
    assign m_out_event_id   = out_id_reg;
    assign m_out_payload    = out_pay_reg;
    assign m_last           = last_reg;
    assign m_unsynced_count = CNT_W'(ucnt_reg);
    assign m_stored_count   = CNT_W'(occ_reg);
    assign m_total_written  = total_reg;
    assign m_overflowed     = ovf_reg;

    a_ucnt_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        ucnt_reg == OCC_W'($countones(pend_reg)))
        else $error("unsynced count out of step with pending bits");

    a_ucnt_le_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        ucnt_reg <= occ_reg)
        else $error("more unsynced records than stored ones");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> full)
        else $error("overflow without a full ring");

endmodule
